FILE: rtl/core/gdn_pkg.sv
// Shared widths, limits and month tables for the Gregorian day number block.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps
`default_nettype none

package gdn_pkg;

    // Field widths
    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int DAYNUM_W = 22;
    localparam int WDAY_W   = 3;
    // full day count before truncation to the output field, eight octal digits
    localparam int TOTAL_W  = 24;
    // quotient of a year by 100 fits in 8 bits
    localparam int CENT_W   = 8;
    // days before a month plus leap day plus day of month
    localparam int OFFS_W   = 9;

    // Last year accepted as a valid date
    localparam logic [YEAR_W-1:0] MAX_YEAR = 14'd9999;

    // Month numbers used by name
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    // x / 100 == (x * RECIP_100) >> RECIP_SHIFT, exact for x < 2**14
    localparam logic [12:0] RECIP_100   = 13'd5243;
    localparam int          RECIP_SHIFT = 19;
    localparam int          PROD100_W   = YEAR_W + 13;

    // Length of each month in a common year
    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] month);
        logic [DAY_W-1:0] len;
        case (month)
            4'd1:    len = 5'd31;
            4'd2:    len = 5'd28;
            4'd3:    len = 5'd31;
            4'd4:    len = 5'd30;
            4'd5:    len = 5'd31;
            4'd6:    len = 5'd30;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd31;
            4'd9:    len = 5'd30;
            4'd10:   len = 5'd31;
            4'd11:   len = 5'd30;
            4'd12:   len = 5'd31;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

    // Days in a common year before the first of each month
    function automatic logic [OFFS_W-1:0] days_before(input logic [MONTH_W-1:0] month);
        logic [OFFS_W-1:0] cum;
        case (month)
            4'd1:    cum = 9'd0;
            4'd2:    cum = 9'd31;
            4'd3:    cum = 9'd59;
            4'd4:    cum = 9'd90;
            4'd5:    cum = 9'd120;
            4'd6:    cum = 9'd151;
            4'd7:    cum = 9'd181;
            4'd8:    cum = 9'd212;
            4'd9:    cum = 9'd243;
            4'd10:   cum = 9'd273;
            4'd11:   cum = 9'd304;
            4'd12:   cum = 9'd334;
            default: cum = 9'd0;
        endcase
        return cum;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/gdn_if.sv
// Valid/ready channels for date requests and day number results.
// Depends on gdn_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

// Date request channel
interface gdn_req_if
    import gdn_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [YEAR_W-1:0]  year_in;
    logic [MONTH_W-1:0] month_in;
    logic [DAY_W-1:0]   day_in;

    modport source (output valid, year_in, month_in, day_in, input ready);
    modport sink   (input valid, year_in, month_in, day_in, output ready);
endinterface

// Result channel
interface gdn_rsp_if
    import gdn_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                date_valid;
    logic [DAYNUM_W-1:0] day_number;
    logic [WDAY_W-1:0]   weekday;
    logic [DAY_W-1:0]    month_length;
    logic                leap;

    modport source (output valid, date_valid, day_number, weekday, month_length, leap,
                    input ready);
    modport sink   (input valid, date_valid, day_number, weekday, month_length, leap,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/core/gregorian_date_to_day_number.sv
// Four register stages: divide by 100, leap and month checks, day count sum,
// weekday fold and output register. Throughput: one request per cycle while
// o_rsp.ready is high; each stage advances when it is empty or the stage after
// it advances, so a stall loses nothing.
// Reset (i_rst_n low, synchronous) clears all stage valid bits.
// Top level of the Gregorian day number block.
// Depends on gdn_pkg and the channel interfaces in gdn_if.sv.
`timescale 1ns / 1ps
`default_nettype none

module gregorian_date_to_day_number
    import gdn_pkg::*;
#(
    parameter logic [YEAR_W-1:0] YEAR_LIMIT = MAX_YEAR
)
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    gdn_req_if.sink    i_req,
    gdn_rsp_if.source  o_rsp
);

    // Stage advance chain
    logic adv1, adv2, adv3, adv4;
    logic r_v1, r_v2, r_v3, r_v4;

    assign adv4 = !r_v4 || o_rsp.ready;
    assign adv3 = !r_v3 || adv4;
    assign adv2 = !r_v2 || adv3;
    assign adv1 = !r_v1 || adv2;
    assign i_req.ready = adv1;

    // Valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_req.valid;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
            if (adv4) r_v4 <= r_v3;
        end
    end

    // ---------------- Stage 1: range check, prior year, divide by 100
    logic [YEAR_W-1:0]    n_prev;
    logic [PROD100_W-1:0] n_prod100;
    logic [TOTAL_W-1:0]   n_p365;
    logic                 n_range_ok;

    logic [YEAR_W-1:0]  r1_prev;
    logic [CENT_W-1:0]  r1_q100;
    logic [TOTAL_W-1:0] r1_p365;
    logic               r1_range_ok;
    logic [MONTH_W-1:0] r1_month;
    logic [DAY_W-1:0]   r1_day;
    logic [1:0]         r1_year_lo;

    always_comb begin
        n_prev     = i_req.year_in - YEAR_W'(1);
        n_prod100  = PROD100_W'(n_prev) * PROD100_W'(RECIP_100);
        n_p365     = TOTAL_W'(n_prev) * TOTAL_W'(365);
        n_range_ok = (i_req.year_in != '0) && (i_req.year_in <= YEAR_LIMIT)
                  && (i_req.month_in >= MONTH_JAN) && (i_req.month_in <= MONTH_DEC);
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r1_prev     <= n_prev;
            r1_q100     <= n_prod100[RECIP_SHIFT +: CENT_W];
            r1_p365     <= n_p365;
            r1_range_ok <= n_range_ok;
            r1_month    <= i_req.month_in;
            r1_day      <= i_req.day_in;
            r1_year_lo  <= i_req.year_in[1:0];
        end
    end

    // ---------------- Stage 2: leap rule, month length, day check
    logic [YEAR_W:0]    n_cent_end;
    logic [CENT_W-1:0]  n_q_year;
    logic               n_leap;
    logic [DAY_W-1:0]   n_mlen;
    logic               n_valid;
    logic [TOTAL_W-1:0] n_base;
    logic [OFFS_W-1:0]  n_offs;

    logic [TOTAL_W-1:0] r2_base;
    logic [OFFS_W-1:0]  r2_offs;
    logic [CENT_W-1:0]  r2_q100;
    logic               r2_valid;
    logic               r2_leap;
    logic [DAY_W-1:0]   r2_mlen;

    always_comb begin
        // year is a multiple of 100 when prior year ends in 99
        n_cent_end = (YEAR_W+1)'(r1_q100) * (YEAR_W+1)'(100) + (YEAR_W+1)'(99);
        n_q_year   = r1_q100 + CENT_W'(1);
        n_leap     = r1_range_ok && (r1_year_lo == 2'd0)
                  && ((n_cent_end != (YEAR_W+1)'(r1_prev)) || (n_q_year[1:0] == 2'd0));
        n_mlen     = month_days(r1_month)
                   + DAY_W'(n_leap && (r1_month == MONTH_FEB));
        n_valid    = r1_range_ok && (r1_day != '0) && (r1_day <= n_mlen);
        n_base     = r1_p365 + TOTAL_W'(r1_prev >> 2);
        n_offs     = days_before(r1_month)
                   + OFFS_W'(n_leap && (r1_month > MONTH_FEB))
                   + OFFS_W'(r1_day);
    end

    always_ff @(posedge i_clk) begin
        if (adv2) begin
            r2_base  <= n_base;
            r2_offs  <= n_offs;
            r2_q100  <= r1_q100;
            r2_valid <= n_valid;
            r2_leap  <= n_leap;
            r2_mlen  <= n_mlen;
        end
    end

    // ---------------- Stage 3: full day count
    logic [TOTAL_W-1:0] n_total;

    logic [TOTAL_W-1:0] r3_total;
    logic               r3_valid;
    logic               r3_leap;
    logic [DAY_W-1:0]   r3_mlen;

    // base is never below q100, so the subtraction cannot wrap
    assign n_total = r2_base + TOTAL_W'(r2_offs) + TOTAL_W'(r2_q100 >> 2)
                   - TOTAL_W'(r2_q100);

    always_ff @(posedge i_clk) begin
        if (adv3) begin
            r3_total <= n_total;
            r3_valid <= r2_valid;
            r3_leap  <= r2_leap;
            r3_mlen  <= r2_mlen;
        end
    end

    // ---------------- Stage 4: weekday by octal digit fold, output register
    logic [5:0]        n_dsum;
    logic [3:0]        n_fold;
    logic [WDAY_W-1:0] n_wday;

    logic                r4_date_valid;
    logic [DAYNUM_W-1:0] r4_day_number;
    logic [WDAY_W-1:0]   r4_weekday;
    logic [DAY_W-1:0]    r4_month_length;
    logic                r4_leap;

    // 8 == 1 mod 7, so the sum of octal digits keeps the residue
    always_comb begin
        n_dsum = '0;
        for (int k = 0; k < 8; k++) begin
            n_dsum = n_dsum + 6'(r3_total[3*k +: 3]);
        end
        n_fold = 4'(n_dsum[5:3]) + 4'(n_dsum[2:0]);
        if (n_fold >= 4'd7) begin
            n_wday = 3'(n_fold - 4'd7);
        end else begin
            n_wday = n_fold[2:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv4) begin
            r4_date_valid   <= r3_valid;
            r4_day_number   <= r3_valid ? r3_total[DAYNUM_W-1:0] : '0;
            r4_weekday      <= r3_valid ? n_wday : '0;
            r4_month_length <= r3_valid ? r3_mlen : '0;
            r4_leap         <= r3_valid && r3_leap;
        end
    end

    assign o_rsp.valid        = r_v4;
    assign o_rsp.date_valid   = r4_date_valid;
    assign o_rsp.day_number   = r4_day_number;
    assign o_rsp.weekday      = r4_weekday;
    assign o_rsp.month_length = r4_month_length;
    assign o_rsp.leap         = r4_leap;

    // ---------------- Checks
    // an accepted request always occupies stage 1 next cycle
    a_req_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> r_v1)
        else $error("accepted request not captured in stage 1");

    // stage 3 content moves into the output register when it advances
    a_out_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && adv4) |=> o_rsp.valid)
        else $error("stage 3 request dropped at output register");

    // nothing is presented right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_rsp.valid)
        else $error("result presented right after reset");

    // a valid date has a nonzero count and a real month length
    a_valid_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.date_valid) |->
            (o_rsp.day_number != '0) && (o_rsp.month_length >= 5'd28)
            && (o_rsp.weekday < 3'd7))
        else $error("valid date with impossible result fields");

    // an invalid date carries zero fields
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.date_valid) |->
            (o_rsp.day_number == '0) && (o_rsp.month_length == '0) && !o_rsp.leap)
        else $error("invalid date with nonzero result fields");

endmodule

`default_nettype wire

FILE: tb/gregorian_date_to_day_number_tb.sv
// Self-checking testbench for the Gregorian day number block: directed and random dates.
// Needs gdn_pkg, the gdn_if.sv channel interfaces and the gregorian_date_to_day_number top.
`timescale 1ns / 1ps

module gregorian_date_to_day_number_tb
    import gdn_pkg::*;
;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int REPORT_MAX     = 10;

    typedef struct packed {
        logic                date_valid;
        logic [DAYNUM_W-1:0] day_number;
        logic [WDAY_W-1:0]   weekday;
        logic [DAY_W-1:0]    month_length;
        logic                leap;
    } t_day_result;

    logic i_clk;
    logic i_rst_n;

    gdn_req_if req_ch ();
    gdn_rsp_if rsp_ch ();

    gregorian_date_to_day_number dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    t_day_result expected_days[$];
    int          idle_cycles    = 0;
    int          mismatch_count = 0;
    int          checked_count  = 0;
    int          sent_count     = 0;
    int          valid_sent     = 0;
    int          burst_left     = 0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Calendar helpers
    function automatic bit gregorian_leap(input int unsigned y);
        return (y != 0) && (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int unsigned days_in_month(input int unsigned y, input int unsigned m);
        int unsigned len;
        case (m)
            4, 6, 9, 11: len = 30;
            2:           len = gregorian_leap(y) ? 29 : 28;
            1, 3, 5, 7, 8, 10, 12: len = 31;
            default:     len = 0;
        endcase
        return len;
    endfunction

    // Expected result for one date request
    function automatic t_day_result calc_day_result(input int unsigned y, input int unsigned m,
                                                    input int unsigned d);
        t_day_result res;
        int unsigned prior;
        int unsigned count;
        int unsigned mlen;
        res = '0;
        if (y < 1 || y > int'(MAX_YEAR) || m < 1 || m > 12)
            return res;
        mlen = days_in_month(y, m);
        if (d < 1 || d > mlen)
            return res;
        prior = y - 1;
        count = prior * 365 + prior / 4 - prior / 100 + prior / 400;
        for (int unsigned k = 1; k < m; k++)
            count += days_in_month(y, k);
        count += d;
        res.date_valid   = 1'b1;
        res.day_number   = count[DAYNUM_W-1:0];
        res.weekday      = WDAY_W'(count % 7);
        res.month_length = mlen[DAY_W-1:0];
        res.leap         = gregorian_leap(y);
        return res;
    endfunction

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    // Request capture, result checking and idle count
    always @(posedge i_clk) begin
        t_day_result want;
        t_day_result got;
        bit          moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready) begin
                expected_days.insert(expected_days.size(),
                                     calc_day_result(req_ch.year_in, req_ch.month_in,
                                                     req_ch.day_in));
                moved = 1'b1;
            end
            if (rsp_ch.valid && rsp_ch.ready) begin
                moved = 1'b1;
                got = '{rsp_ch.date_valid, rsp_ch.day_number, rsp_ch.weekday,
                        rsp_ch.month_length, rsp_ch.leap};
                if (expected_days.size() == 0) begin
                    note_mismatch($sformatf("result with nothing pending: %p", got));
                end else begin
                    want = expected_days.pop_front();
                    checked_count++;
                    if (got.date_valid !== want.date_valid || got.day_number !== want.day_number
                        || got.weekday !== want.weekday
                        || got.month_length !== want.month_length || got.leap !== want.leap)
                        note_mismatch($sformatf(
                            "valid %0b/%0b daynum %0d/%0d wday %0d/%0d mlen %0d/%0d leap %0b/%0b",
                            want.date_valid, got.date_valid, want.day_number, got.day_number,
                            want.weekday, got.weekday, want.month_length, got.month_length,
                            want.leap, got.leap));
                end
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
    end

    // Result backpressure: the stall mode is drawn anew at random, periodically
    initial begin
        int mode;
        int phase;
        mode  = 0;
        phase = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (phase % 50 == 0)
                mode = $urandom_range(0, 3);
            phase++;
            case (mode)
                0:       rsp_ch.ready <= 1'b1;
                1:       rsp_ch.ready <= ($urandom_range(0, 3) != 0);
                2:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                default: rsp_ch.ready <= (phase % 3 == 0);
            endcase
        end
    end

    // Watchdog on cycles with no handshake on either channel
    initial begin
        while (idle_cycles < WATCHDOG_LIMIT)
            @(posedge i_clk);
        $display("watchdog: no traffic for %0d cycles, %0d results pending",
                 WATCHDOG_LIMIT, expected_days.size());
        $display("gregorian_date_to_day_number verification failed");
        $finish;
    end

    // One date request; valid stays high inside a burst
    task automatic send_date(input int unsigned y, input int unsigned m, input int unsigned d);
        int gap;
        if (burst_left == 0) begin
            gap        = $urandom_range(0, 8);
            burst_left = $urandom_range(1, 40);
            if (gap != 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        req_ch.valid    <= 1'b1;
        req_ch.year_in  <= y[YEAR_W-1:0];
        req_ch.month_in <= m[MONTH_W-1:0];
        req_ch.day_in   <= d[DAY_W-1:0];
        do @(posedge i_clk); while (!req_ch.ready);
        sent_count++;
        if (calc_day_result(y, m, d).date_valid)
            valid_sent++;
    endtask

    // Field extremes, century rules and month ends
    task automatic test_directed_dates();
        send_date(1, 1, 1);
        send_date(MAX_YEAR, 12, 31);
        send_date(0, 1, 1);
        send_date(MAX_YEAR + 1, 1, 1);
        send_date(16383, 15, 31);
        send_date(2024, 0, 10);
        send_date(2024, 13, 10);
        send_date(2024, 15, 10);
        send_date(2024, 6, 0);
        send_date(2024, 1, 31);
        send_date(2024, 4, 31);
        send_date(2000, 2, 29);
        send_date(1900, 2, 29);
        send_date(1900, 2, 28);
        send_date(2024, 2, 29);
        send_date(2023, 2, 29);
        send_date(2400, 2, 29);
        send_date(2000, 3, 1);
        send_date(1999, 12, 31);
        send_date(4, 2, 29);
        send_date(100, 2, 29);
        send_date(400, 12, 31);
        send_date(0, 0, 0);
        send_date(MAX_YEAR, 2, 28);
        send_date(9996, 2, 29);
    endtask

    // Well-formed dates across the whole year range, biased to the edges
    task automatic test_random_valid_dates(input int n);
        int unsigned y;
        int unsigned m;
        int unsigned d;
        int unsigned len;
        repeat (n) begin
            case ($urandom_range(0, 9))
                0:       y = $urandom_range(1, 4);
                1:       y = $urandom_range(MAX_YEAR - 3, MAX_YEAR);
                default: y = $urandom_range(1, MAX_YEAR);
            endcase
            m   = $urandom_range(1, 12);
            len = days_in_month(y, m);
            case ($urandom_range(0, 5))
                0:       d = 1;
                1:       d = len;
                default: d = $urandom_range(1, len);
            endcase
            send_date(y, m, d);
        end
    endtask

    // Century and quad-century years around February and year ends
    task automatic test_leap_boundaries(input int n);
        int unsigned y;
        int unsigned m;
        int unsigned d;
        repeat (n) begin
            case ($urandom_range(0, 3))
                0:       y = 100 * $urandom_range(1, MAX_YEAR / 100);
                1:       y = 400 * $urandom_range(1, MAX_YEAR / 400);
                2:       y = 4 * $urandom_range(1, MAX_YEAR / 4);
                default: y = $urandom_range(1, MAX_YEAR);
            endcase
            case ($urandom_range(0, 3))
                0: begin m = 2;  d = $urandom_range(27, 30); end
                1: begin m = 3;  d = 1;                      end
                2: begin m = 12; d = $urandom_range(30, 31); end
                default: begin
                    m = $urandom_range(1, 12);
                    d = days_in_month(y, m) + $urandom_range(0, 1);
                end
            endcase
            send_date(y, m, d);
        end
    endtask

    // Raw field noise, plus dates with a zero day or a day from the month end up, and years from MAX_YEAR up
    task automatic test_malformed_dates(input int n);
        int unsigned y;
        int unsigned m;
        int unsigned d;
        repeat (n) begin
            y = $urandom_range(0, 16383);
            m = $urandom_range(0, 15);
            d = $urandom_range(0, 31);
            case ($urandom_range(0, 3))
                0: begin
                    y = $urandom_range(1, MAX_YEAR);
                    m = $urandom_range(1, 12);
                    d = ($urandom_range(0, 1) != 0) ? 0
                        : $urandom_range(days_in_month(y, m), 31);
                end
                1: y = $urandom_range(MAX_YEAR, 16383);
                default: ;
            endcase
            send_date(y, m, d);
        end
    endtask

    // Sequence of tests
    initial begin
        i_rst_n         <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.year_in  <= '0;
        req_ch.month_in <= '0;
        req_ch.day_in   <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_dates();
        test_random_valid_dates(500);
        test_leap_boundaries(200);
        test_malformed_dates(200);

        req_ch.valid <= 1'b0;
        while (expected_days.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d date requests (%0d well-formed), checked %0d results",
                 sent_count, valid_sent, checked_count);
        $display("mismatches: %0d, still pending: %0d", mismatch_count, expected_days.size());
        if (mismatch_count == 0 && expected_days.size() == 0)
            $display("gregorian_date_to_day_number verification clean");
        else
            $display("gregorian_date_to_day_number verification failed");
        $finish;
    end

endmodule
